// ----- rtl/sbsh_pkg.sv -----
// ----------------------------------------------------------------------------
// sbsh_pkg: shared types and helpers of the segment/box slab hit block
// Transaction payloads, cell control word, register map and the signed
// fraction ordering used by every compare cell.
// ----------------------------------------------------------------------------
package sbsh_pkg;

	// register map, index of each register (byte address is 4 * index)
	localparam logic [2:0] REG_BOX_VALID = 3'd0;
	localparam logic [2:0] REG_BOX_MIN_X = 3'd1;
	localparam logic [2:0] REG_BOX_MIN_Y = 3'd2;
	localparam logic [2:0] REG_BOX_MIN_Z = 3'd3;
	localparam logic [2:0] REG_BOX_MAX_X = 3'd4;
	localparam logic [2:0] REG_BOX_MAX_Y = 3'd5;
	localparam logic [2:0] REG_BOX_MAX_Z = 3'd6;

	// input transaction
	typedef struct packed {
		logic signed [31:0] start_x;
		logic signed [31:0] start_y;
		logic signed [31:0] start_z;
		logic signed [31:0] end_x;
		logic signed [31:0] end_y;
		logic signed [31:0] end_z;
	} sbsh_in_t;

	// result transaction
	typedef struct packed {
		logic        hit;
		logic [31:0] entry_num;
		logic [31:0] entry_den;
	} sbsh_out_t;

	// control word carried alongside each item through the cell chain
	typedef struct packed {
		logic vld;
		logic miss;
	} sbsh_ctl_t;

	// a < b for fractions with positive denominators, given the signs of the
	// numerators and the ordering of the cross products a.mag*b.den, b.mag*a.den
	function automatic logic sbsh_frac_lt(input logic a_neg, input logic a_zero,
			input logic b_neg, input logic b_zero, input logic mag_lt, input logic mag_gt);
		logic a_pos;
		logic a_n;
		logic b_pos;
		logic b_n;
		a_pos = !a_zero && !a_neg;
		a_n   = !a_zero && a_neg;
		b_pos = !b_zero && !b_neg;
		b_n   = !b_zero && b_neg;
		return (a_n && !b_n) || (a_zero && b_pos) || (a_pos && b_pos && mag_lt)
			|| (a_n && b_n && mag_gt);
	endfunction

endpackage

// ----- rtl/sbsh_cell.sv -----
// ----------------------------------------------------------------------------
// sbsh_cell: one slab compare cell
// Narrows the entry bound (first three cells) or the exit bound (last three)
// against one axis candidate. Cross products in the first stage, compare and
// update in the second; all candidates pass on to the next cell.
// ----------------------------------------------------------------------------
module sbsh_cell #(
	parameter int CB  = 32,
	parameter int IDX = 0,
	localparam int F  = 1 + 2 * CB
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  sbsh_pkg::sbsh_ctl_t   ctl_i,
	input  logic [5:0][F-1:0]     cand_i,
	input  logic [2:0]            skip_i,
	input  logic [F-1:0]          tmin_i,
	input  logic [F-1:0]          tmax_i,
	output sbsh_pkg::sbsh_ctl_t   ctl_o,
	output logic [5:0][F-1:0]     cand_o,
	output logic [2:0]            skip_o,
	output logic [F-1:0]          tmin_o,
	output logic [F-1:0]          tmax_o
);

	localparam bit EXIT = (IDX >= 3);
	localparam int AX   = IDX % 3;

	logic [F-1:0]      a_c;
	logic [F-1:0]      b_c;
	logic [2*CB-1:0]   l_c;
	logic [2*CB-1:0]   r_c;

	sbsh_pkg::sbsh_ctl_t ctl_s1;
	logic [5:0][F-1:0] cand_s1;
	logic [2:0]        skip_s1;
	logic [F-1:0]      tmin_s1;
	logic [F-1:0]      tmax_s1;
	logic [2*CB-1:0]   l_s1;
	logic [2*CB-1:0]   r_s1;

	logic [F-1:0]      cv;
	logic [F-1:0]      a2;
	logic [F-1:0]      b2;
	logic              take;

	sbsh_pkg::sbsh_ctl_t ctl_s2;
	logic [5:0][F-1:0] cand_s2;
	logic [2:0]        skip_s2;
	logic [F-1:0]      tmin_s2;
	logic [F-1:0]      tmax_s2;

	// pick operands and form the cross products
	always_comb begin
		a_c = EXIT ? cand_i[IDX] : tmin_i;
		b_c = EXIT ? tmax_i : cand_i[IDX];
		l_c = a_c[2*CB-1:CB] * b_c[CB-1:0];
		r_c = b_c[2*CB-1:CB] * a_c[CB-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cand_s1 <= cand_i;
			skip_s1 <= skip_i;
			tmin_s1 <= tmin_i;
			tmax_s1 <= tmax_i;
			l_s1    <= l_c;
			r_s1    <= r_c;
		end
	end

	// compare and narrow the bound, skipping an axis parallel to the segment
	always_comb begin
		cv   = cand_s1[IDX];
		a2   = EXIT ? cv : tmin_s1;
		b2   = EXIT ? tmax_s1 : cv;
		take = !skip_s1[AX] && sbsh_pkg::sbsh_frac_lt(a2[F-1], a2[2*CB-1:CB] == '0,
			b2[F-1], b2[2*CB-1:CB] == '0, l_s1 < r_s1, l_s1 > r_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (en) begin
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cand_s2 <= cand_s1;
			skip_s2 <= skip_s1;
			tmin_s2 <= (!EXIT && take) ? cv : tmin_s1;
			tmax_s2 <= (EXIT && take) ? cv : tmax_s1;
		end
	end

	assign ctl_o  = ctl_s2;
	assign cand_o = cand_s2;
	assign skip_o = skip_s2;
	assign tmin_o = tmin_s2;
	assign tmax_o = tmax_s2;

endmodule

// ----- rtl/sbsh_tail.sv -----
// ----------------------------------------------------------------------------
// sbsh_tail: final interval check and result register
// Reports a hit when the item survived the parallel-axis and empty-box tests
// and the exit bound does not lie below the entry bound.
// ----------------------------------------------------------------------------
module sbsh_tail #(
	parameter int CB = 32,
	localparam int F = 1 + 2 * CB
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  sbsh_pkg::sbsh_ctl_t  ctl_i,
	input  logic [F-1:0]         tmin_i,
	input  logic [F-1:0]         tmax_i,
	output logic                 out_vld,
	output sbsh_pkg::sbsh_out_t  out_data
);

	sbsh_pkg::sbsh_ctl_t ctl_s1;
	logic [F-1:0]      tmin_s1;
	logic [F-1:0]      tmax_s1;
	logic [2*CB-1:0]   l_s1;
	logic [2*CB-1:0]   r_s1;
	logic              bad;
	logic              hit;
	logic              vld_s2;
	sbsh_pkg::sbsh_out_t res_s2;

	// cross products of exit against entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tmin_s1 <= tmin_i;
			tmax_s1 <= tmax_i;
			l_s1    <= tmax_i[2*CB-1:CB] * tmin_i[CB-1:0];
			r_s1    <= tmin_i[2*CB-1:CB] * tmax_i[CB-1:0];
		end
	end

	// miss when the interval is empty
	always_comb begin
		bad = sbsh_pkg::sbsh_frac_lt(tmax_s1[F-1], tmax_s1[2*CB-1:CB] == '0,
			tmin_s1[F-1], tmin_s1[2*CB-1:CB] == '0, l_s1 < r_s1, l_s1 > r_s1);
		hit = !ctl_s1.miss && !bad;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= ctl_s1.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s2.hit       <= hit;
			res_s2.entry_num <= hit ? 32'(tmin_s1[2*CB-1:CB]) : 32'd0;
			res_s2.entry_den <= hit ? 32'(tmin_s1[CB-1:0]) : 32'd1;
		end
	end

	assign out_vld  = vld_s2;
	assign out_data = res_s2;

endmodule

// ----- rtl/segment_box_slab_hit_top.sv -----
// ----------------------------------------------------------------------------
// segment_box_slab_hit_top: exact slab test of a segment against a box
// Pipeline: one candidate stage, six two-stage compare cells, and a
// two-stage final check ending in the result register.
// Throughput one transaction per cycle; the whole chain stalls only while a
// result waits at the output. Each cell has two 32x32 multipliers.
// Reset clears the valid bits and the box registers (empty box, bounds 0).
// ----------------------------------------------------------------------------
module segment_box_slab_hit_top #(
	parameter int COORD_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [4:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	input  logic                in_valid,
	output logic                in_ready,
	input  sbsh_pkg::sbsh_in_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output sbsh_pkg::sbsh_out_t out_data
);

	localparam int CB = COORD_BITS;
	localparam int W  = CB + 1;
	localparam int F  = 1 + 2 * CB;

	logic              box_valid_q;
	logic [2:0][31:0]  box_min_q;
	logic [2:0][31:0]  box_max_q;
	logic [2:0]        reg_idx;
	logic              wr;
	logic              en;

	logic [2:0][31:0]  st;
	logic [2:0][31:0]  ed;
	logic [2:0]        par_c;
	logic [2:0]        pfail_c;
	logic [5:0][F-1:0] cand_c;

	sbsh_pkg::sbsh_ctl_t ctl_s1;
	logic [5:0][F-1:0] cand_s1;
	logic [2:0]        skip_s1;

	sbsh_pkg::sbsh_ctl_t ctl_ch [7];
	logic [5:0][F-1:0] cand_ch [7];
	logic [2:0]        skip_ch [7];
	logic [F-1:0]      tmin_ch [7];
	logic [F-1:0]      tmax_ch [7];

	// configuration writes
	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign wr      = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_valid_q <= 1'b0;
			box_min_q   <= '0;
			box_max_q   <= '0;
		end else if (wr) begin
			unique case (reg_idx)
				sbsh_pkg::REG_BOX_VALID: box_valid_q  <= pwdata[0];
				sbsh_pkg::REG_BOX_MIN_X: box_min_q[0] <= pwdata;
				sbsh_pkg::REG_BOX_MIN_Y: box_min_q[1] <= pwdata;
				sbsh_pkg::REG_BOX_MIN_Z: box_min_q[2] <= pwdata;
				sbsh_pkg::REG_BOX_MAX_X: box_max_q[0] <= pwdata;
				sbsh_pkg::REG_BOX_MAX_Y: box_max_q[1] <= pwdata;
				sbsh_pkg::REG_BOX_MAX_Z: box_max_q[2] <= pwdata;
				default: ;
			endcase
		end
	end

	// register read-back
	always_comb begin
		unique case (reg_idx)
			sbsh_pkg::REG_BOX_VALID: prdata = {31'd0, box_valid_q};
			sbsh_pkg::REG_BOX_MIN_X: prdata = box_min_q[0];
			sbsh_pkg::REG_BOX_MIN_Y: prdata = box_min_q[1];
			sbsh_pkg::REG_BOX_MIN_Z: prdata = box_min_q[2];
			sbsh_pkg::REG_BOX_MAX_X: prdata = box_max_q[0];
			sbsh_pkg::REG_BOX_MAX_Y: prdata = box_max_q[1];
			sbsh_pkg::REG_BOX_MAX_Z: prdata = box_max_q[2];
			default:                 prdata = 32'd0;
		endcase
	end

	// advance the whole chain unless a result is held at the output
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	assign st[0] = in_data.start_x;
	assign st[1] = in_data.start_y;
	assign st[2] = in_data.start_z;
	assign ed[0] = in_data.end_x;
	assign ed[1] = in_data.end_y;
	assign ed[2] = in_data.end_z;

	// per axis: parallel test and entry/exit candidate fractions
	for (genvar a = 0; a < 3; a++) begin : g_axis
		logic signed [W-1:0] s;
		logic signed [W-1:0] e;
		logic signed [W-1:0] lo;
		logic signed [W-1:0] hi;
		logic signed [W-1:0] dd;
		logic signed [W-1:0] n_in;
		logic signed [W-1:0] n_out;
		logic signed [W-1:0] dn;
		logic signed [W-1:0] m_in;
		logic signed [W-1:0] m_out;
		logic                dpos;

		always_comb begin
			s      = W'(signed'(st[a][CB-1:0]));
			e      = W'(signed'(ed[a][CB-1:0]));
			lo     = W'(signed'(box_min_q[a][CB-1:0]));
			hi     = W'(signed'(box_max_q[a][CB-1:0]));
			dpos   = e > s;
			dd     = e - s;
			dn     = dpos ? dd : -dd;
			n_in   = dpos ? (lo - s) : (s - hi);
			n_out  = dpos ? (hi - s) : (s - lo);
			m_in   = n_in[W-1] ? -n_in : n_in;
			m_out  = n_out[W-1] ? -n_out : n_out;
			par_c[a]   = (e == s);
			pfail_c[a] = par_c[a] && ((s < lo) || (s > hi));
			cand_c[a]     = {n_in[W-1], m_in[CB-1:0], dn[CB-1:0]};
			cand_c[a + 3] = {n_out[W-1], m_out[CB-1:0], dn[CB-1:0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1.vld  <= in_valid;
			ctl_s1.miss <= !box_valid_q || (|pfail_c);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cand_s1 <= cand_c;
			skip_s1 <= par_c;
		end
	end

	// chain head: interval starts at [0, 1]
	assign ctl_ch[0]  = ctl_s1;
	assign cand_ch[0] = cand_s1;
	assign skip_ch[0] = skip_s1;
	assign tmin_ch[0] = {1'b0, CB'(0), CB'(1)};
	assign tmax_ch[0] = {1'b0, CB'(1), CB'(1)};

	for (genvar k = 0; k < 6; k++) begin : g_cell
		sbsh_cell #(
			.CB  (CB),
			.IDX (k)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.ctl_i  (ctl_ch[k]),
			.cand_i (cand_ch[k]),
			.skip_i (skip_ch[k]),
			.tmin_i (tmin_ch[k]),
			.tmax_i (tmax_ch[k]),
			.ctl_o  (ctl_ch[k+1]),
			.cand_o (cand_ch[k+1]),
			.skip_o (skip_ch[k+1]),
			.tmin_o (tmin_ch[k+1]),
			.tmax_o (tmax_ch[k+1])
		);
	end

	sbsh_tail #(
		.CB (CB)
	) u_tail (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.ctl_i    (ctl_ch[6]),
		.tmin_i   (tmin_ch[6]),
		.tmax_i   (tmax_ch[6]),
		.out_vld  (out_valid),
		.out_data (out_data)
	);

	// a miss carries the fraction 0/1
	a_miss_frac: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.hit) |-> (out_data.entry_num == 32'd0
			&& out_data.entry_den == 32'd1))
		else $error("miss result with a non-trivial fraction");

	// a hit lies within the segment
	a_hit_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.hit) |-> (out_data.entry_num <= out_data.entry_den
			&& out_data.entry_den != 32'd0))
		else $error("hit parameter outside [0, 1]");

	// the chain takes a transaction whenever the output register is free
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with an empty output register");

endmodule
